>>> hw/rtl/otsu_threshold_finder_assert.svh
// assertion macros for the otsu threshold finder
// expects clk and rst_n in the scope where a macro is used
`ifndef OTSU_THRESHOLD_FINDER_ASSERT_SVH
`define OTSU_THRESHOLD_FINDER_ASSERT_SVH

// condition holds in the same cycle
`define OTF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("otsu threshold finder check failed");

// condition holds in the next cycle
`define OTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("otsu threshold finder check failed");

`endif

>>> hw/rtl/otf_pkg.sv
// shared constants, types and command structs of the otsu threshold finder
// no dependencies
package otf_pkg;

    localparam int LEVELS     = 256;
    localparam int COUNT_BITS = 22;
    localparam int PIX_W      = 8;
    localparam int THR_W      = 8;
    localparam int IDX_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SUM_W      = COUNT_BITS + IDX_W;
    localparam int PROD_W     = SUM_W + COUNT_BITS;
    localparam int NUM_W      = 2 * PROD_W;
    localparam int DEN_W      = 2 * COUNT_BITS;
    localparam int MA_W       = NUM_W;
    localparam int MB_W       = PROD_W;
    localparam int DIG        = 8;
    localparam int STEPS      = (MB_W + DIG - 1) / DIG;
    localparam int BP_W       = STEPS * DIG;
    localparam int P_W        = MA_W + MB_W;
    localparam int CNT_W      = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_BIN_RD,
        ST_BIN_ACC,
        ST_MUL_P,
        ST_MUL_Q,
        ST_MUL_SQ,
        ST_MUL_DEN,
        ST_MUL_L,
        ST_MUL_R,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MS_P,
        MS_Q,
        MS_SQ,
        MS_DEN,
        MS_L,
        MS_R
    } mul_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     init;
        logic     rd_en;
        logic     sum_acc;
        logic     bin_acc;
        logic     mul_run;
        mul_sel_t mul_sel;
        logic     cmp;
        logic     idx_inc;
        logic     finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic last_in;
        logic mul_done;
        logic idx_last;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> hw/rtl/otsu_threshold_finder.sv
// top level of the otsu threshold finder: controller plus datapath
// depends on otf_pkg, otf_ctrl, otf_datapath and the assertion header
//
//   channel   dir   tdata              tlast       tuser
//   s_*       in    [7:0] pixel        last_pixel  -
//   m_*       out   [7:0] threshold    -           -
//
// pixels are taken one per cycle until the item marked last
// the sweep then makes a sum pass and a score pass over all 256 levels, paced by the
// shared multiplier that takes one 8-bit digit per cycle, six products per level
// s_tready is low from the last pixel until the result is loaded
// the result waits in an output register; a new image may stream in meanwhile
// reset leaves the histogram empty through per-bin valid bits
`include "otsu_threshold_finder_assert.svh"

module otsu_threshold_finder
    import otf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pixel
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] threshold
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    otf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    otf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_valid  (s_tvalid),
        .pixel     (s_tdata),
        .last      (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .threshold (m_tdata)
    );

    assign s_tready = cmd.in_ready;

    `OTF_ASSERT_NEXT(a_last_stops_input, s_tvalid && s_tready && s_tlast, !s_tready)
    `OTF_ASSERT_SAME(a_result_after_sweep, $rose(m_tvalid), !$past(s_tready))
    `OTF_ASSERT_SAME(a_no_sweep_read_on_accept, s_tready, !cmd.rd_en && !cmd.mul_run)

endmodule

>>> hw/rtl/otf_mul.sv
// shared multi-cycle multiplier, one 8-bit digit of b per cycle
// depends on otf_pkg
module otf_mul
    import otf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            run,
    input  logic [MA_W-1:0] a,
    input  logic [MB_W-1:0] b,
    output logic            done,
    output logic [P_W-1:0]  p
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [MA_W-1:0]       a_reg;
    logic [BP_W-1:0]       b_reg;
    logic [P_W-1:0]        acc_reg;
    logic [P_W-1:0]        acc_next;
    logic [MA_W+DIG-1:0]   part;
    logic                  load;

    assign load     = run && !busy_reg && !done_reg;
    assign part     = a_reg * b_reg[BP_W-1 -: DIG];
    assign acc_next = (acc_reg << DIG) + P_W'(part);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // msb digit first, accumulator shifts left each step
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg   <= a;
            b_reg   <= BP_W'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << DIG;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

>>> hw/rtl/otf_datapath.sv
// histogram memory, class sums, score registers and output register
// depends on otf_pkg and otf_mul
module otf_datapath
    import otf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_cmd_t         cmd,
    output dp_stat_t         stat,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] pixel,
    input  logic             last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [THR_W-1:0] threshold
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] mem [LEVELS];
    logic [COUNT_BITS-1:0] mem_q;
    logic [LEVELS-1:0]     vld_bits_reg;
    logic                  vld_reg;
    logic                  fwd_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] rd_val;

    logic                  s1_v_reg;
    logic [IDX_W-1:0]      s1_a_reg;
    logic [IDX_W-1:0]      level;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_en;
    logic                  in_acc;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;

    logic [COUNT_BITS-1:0] tot_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SUM_W-1:0]      s_all_reg;
    logic [SUM_W-1:0]      s_a_reg;
    logic [COUNT_BITS-1:0] n_a_reg;
    logic [COUNT_BITS-1:0] n_b;
    logic [SUM_W-1:0]      bin_w;
    logic [PROD_W-1:0]     p_reg;
    logic [PROD_W-1:0]     q_reg;
    logic [PROD_W-1:0]     diff;
    logic [NUM_W-1:0]      num_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [NUM_W-1:0]      best_num_reg;
    logic [DEN_W-1:0]      best_den_reg;
    logic [IDX_W-1:0]      best_reg;
    logic [P_W-1:0]        lhs_reg;
    logic [P_W-1:0]        rhs_reg;
    logic                  zero_cls;

    logic                  out_valid_reg;
    logic [THR_W-1:0]      thr_reg;

    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic                  mul_done;
    logic [P_W-1:0]        mul_p;

    // gray levels at or above the bin count fall into the top bin
    assign level   = ({1'b0, pixel} >= (PIX_W + 1)'(LEVELS)) ? IDX_W'(LEVELS - 1)
                                                            : IDX_W'(pixel);
    assign in_acc  = in_valid && cmd.in_ready;
    assign rd_en   = in_acc || cmd.rd_en;
    assign rd_addr = in_acc ? level : idx_reg;
    assign rd_val  = fwd_reg ? fwd_data_reg : (vld_reg ? mem_q : '0);
    assign wr_en   = s1_v_reg && (tot_reg < COUNT_MAX);
    assign wr_data = rd_val + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_a_reg] <= wr_data;
        if (rd_en)
            mem_q <= mem[rd_addr];
    end

    // back-to-back pixels of the same level see the pending write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_reg      <= wr_en && (s1_a_reg == rd_addr);
            fwd_data_reg <= wr_data;
            vld_reg      <= vld_bits_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_bits_reg  <= '0;
            s1_v_reg      <= 1'b0;
            tot_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= in_acc;
            if (cmd.finish)
            begin
                vld_bits_reg <= '0;
                tot_reg      <= '0;
            end
            else if (wr_en)
            begin
                vld_bits_reg[s1_a_reg] <= 1'b1;
                tot_reg                <= tot_reg + 1'b1;
            end
            if (cmd.idx_inc)
                idx_reg <= stat.idx_last ? '0 : idx_reg + 1'b1;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign n_b      = tot_reg - n_a_reg;
    assign zero_cls = (n_a_reg == '0) || (n_b == '0);
    assign bin_w    = idx_reg * rd_val;
    assign diff     = (p_reg >= q_reg) ? (p_reg - q_reg) : (q_reg - p_reg);

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_P:
            begin
                mul_a = MA_W'(s_a_reg);
                mul_b = MB_W'(tot_reg);
            end
            MS_Q:
            begin
                mul_a = MA_W'(s_all_reg);
                mul_b = MB_W'(n_a_reg);
            end
            MS_SQ:
            begin
                mul_a = MA_W'(diff);
                mul_b = MB_W'(diff);
            end
            MS_DEN:
            begin
                mul_a = MA_W'(n_a_reg);
                mul_b = MB_W'(n_b);
            end
            MS_L:
            begin
                mul_a = MA_W'(num_reg);
                mul_b = MB_W'(best_den_reg);
            end
            MS_R:
            begin
                mul_a = MA_W'(best_num_reg);
                mul_b = MB_W'(den_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    otf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .run   (cmd.mul_run),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_ff @(posedge clk)
    begin
        s1_a_reg <= level;
        if (cmd.init)
        begin
            s_all_reg    <= '0;
            s_a_reg      <= '0;
            n_a_reg      <= '0;
            best_num_reg <= '0;
            best_den_reg <= DEN_W'(1);
            best_reg     <= '0;
        end
        if (cmd.sum_acc)
            s_all_reg <= s_all_reg + bin_w;
        if (cmd.bin_acc)
        begin
            s_a_reg <= s_a_reg + bin_w;
            n_a_reg <= n_a_reg + rd_val;
        end
        if (mul_done)
        begin
            unique case (cmd.mul_sel)
                MS_P:    p_reg   <= PROD_W'(mul_p);
                MS_Q:    q_reg   <= PROD_W'(mul_p);
                MS_SQ:   num_reg <= zero_cls ? '0 : NUM_W'(mul_p);
                MS_DEN:  den_reg <= zero_cls ? DEN_W'(1) : DEN_W'(mul_p);
                MS_L:    lhs_reg <= mul_p;
                MS_R:    rhs_reg <= mul_p;
                default: ;
            endcase
        end
        // level zero seeds the running best, later ones must beat it strictly
        if (cmd.cmp && ((idx_reg == '0) || (lhs_reg > rhs_reg)))
        begin
            best_num_reg <= num_reg;
            best_den_reg <= den_reg;
            best_reg     <= idx_reg;
        end
        if (cmd.finish)
            thr_reg <= THR_W'(best_reg);
    end

    assign stat.last_in  = in_acc && last;
    assign stat.mul_done = mul_done;
    assign stat.idx_last = (idx_reg == IDX_W'(LEVELS - 1));
    assign stat.out_busy = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign threshold = thr_reg;

endmodule

>>> hw/rtl/otf_ctrl.sv
// sequencer for pixel counting, the sum pass and the per-level score sweep
// depends on otf_pkg
module otf_ctrl
    import otf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MS_P;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.last_in)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cmd.init   = 1'b1;
                state_next = ST_SUM_RD;
            end
            ST_SUM_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = stat.idx_last ? ST_BIN_RD : ST_SUM_RD;
            end
            ST_BIN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_BIN_ACC;
            end
            ST_BIN_ACC:
            begin
                cmd.bin_acc = 1'b1;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = MS_P;
                if (stat.mul_done)
                    state_next = ST_MUL_Q;
            end
            ST_MUL_Q:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = MS_Q;
                if (stat.mul_done)
                    state_next = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = MS_SQ;
                if (stat.mul_done)
                    state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = MS_DEN;
                if (stat.mul_done)
                    state_next = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = MS_L;
                if (stat.mul_done)
                    state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = MS_R;
                if (stat.mul_done)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp     = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = stat.idx_last ? ST_OUT : ST_BIN_RD;
            end
            ST_OUT:
            begin
                // wait for the previous threshold to leave the output register
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
